// ===== src/gsc_pkg.sv =====
// Shared types and constants for the convex hull block.
`default_nettype none
package gsc_pkg;

    localparam int MIN_POINTS = 3;

    localparam logic [1:0] STATUS_HULL  = 2'd0;
    localparam logic [1:0] STATUS_FEW   = 2'd1;
    localparam logic [1:0] STATUS_DEGEN = 2'd2;

    // point store write data source
    typedef enum logic [1:0] {
        WS_IN,
        WS_T,
        WS_Q,
        WS_PV
    } t_wsel;

    // operand sets for the geometry unit
    typedef enum logic [1:0] {
        GS_PTQ,   // turn(pivot, t, q)
        GS_ABT,   // turn(a, b, t)
        GS_DT,    // dist2(t, pivot)
        GS_DQ     // dist2(q, pivot)
    } t_gsel;

    typedef struct packed {
        logic       pt_re;
        logic       pt_we;
        t_wsel      wsel;
        logic       ld_pv;
        logic       ld_t;
        logic       ld_q;
        logic       t_from_q;
        logic       ld_a;
        logic       ld_b;
        logic       a_from_b;
        logic       b_from_a;
        logic       b_from_t;
        logic       g_start;
        t_gsel      gsel;
        logic       ld_dt;
        logic       st_re;
        logic       st_we;
        logic       out_ld;
        logic       out_zero;
        logic [1:0] out_status;
        logic       out_last;
        logic       out_ovf;
    } t_cmd;

    typedef struct packed {
        logic pt_lt;     // read point is lower than the current pivot
        logic g_done;
        logic g_pos;     // result strictly positive
        logic g_zero;
        logic t_nearer;  // dist2(t) < geometry result
    } t_stat;

endpackage
`default_nettype wire

// ===== src/gsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsc_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/gsc_geom.sv =====
// Shared multiply-accumulate unit: cross product turn test or squared 3D distance.
`default_nettype none
module gsc_geom #(
    parameter int COORD_BITS = 16,
    localparam int PW = 3 * COORD_BITS,
    localparam int DW = COORD_BITS + 1,
    localparam int MW = 2 * DW,
    localparam int AW = 2 * COORD_BITS + 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_dist,
    input  wire logic [PW-1:0] i_a,
    input  wire logic [PW-1:0] i_b,
    input  wire logic [PW-1:0] i_c,
    output logic               o_done,
    output logic [AW-1:0]      o_res
);

    logic          r_busy;
    logic [1:0]    r_step;
    logic          r_dist;
    logic          r_v1, r_v2;
    logic          r_last1, r_last2;
    logic          r_sub1, r_sub2;
    logic signed [DW-1:0] r_opa, r_opb;
    logic signed [MW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    logic          issue_last;
    logic          issue_sub;
    logic signed [DW-1:0] n_opa, n_opb;

    function automatic logic signed [DW-1:0] coord(input logic [PW-1:0] p, input int k);
        logic [COORD_BITS-1:0] v;
        v = p[k*COORD_BITS +: COORD_BITS];
        return $signed({v[COORD_BITS-1], v});
    endfunction

    always_comb begin
        issue_last = 1'b0;
        issue_sub  = 1'b0;
        n_opa      = '0;
        n_opb      = '0;
        if (r_dist) begin
            issue_last = (r_step == 2'd2);
            case (r_step)
                2'd0:    n_opa = coord(i_a, 0) - coord(i_b, 0);
                2'd1:    n_opa = coord(i_a, 1) - coord(i_b, 1);
                default: n_opa = coord(i_a, 2) - coord(i_b, 2);
            endcase
            n_opb = n_opa;
        end else begin
            issue_last = (r_step == 2'd1);
            if (r_step == 2'd0) begin
                n_opa = coord(i_b, 0) - coord(i_a, 0);
                n_opb = coord(i_c, 1) - coord(i_b, 1);
            end else begin
                n_opa     = coord(i_b, 1) - coord(i_a, 1);
                n_opb     = coord(i_c, 0) - coord(i_b, 0);
                issue_sub = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= r_busy;
            r_v2   <= r_v1;
            o_done <= r_v2 & r_last2;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && issue_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= 2'd0;
            r_dist <= i_dist;
            r_acc  <= '0;
        end else begin
            if (r_busy) begin
                r_step <= r_step + 2'd1;
            end
            if (r_v2) begin
                if (r_sub2) begin
                    r_acc <= r_acc - AW'(r_prod);
                end else begin
                    r_acc <= r_acc + AW'(r_prod);
                end
            end
        end
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_last1 <= issue_last;
        r_sub1  <= issue_sub;
        r_prod  <= r_opa * r_opb;
        r_last2 <= r_last1;
        r_sub2  <= r_sub1;
    end

    assign o_res = r_acc;

endmodule
`default_nettype wire

// ===== src/gsc_dp.sv =====
// Datapath: point store, hull stack, point registers, geometry unit and result registers.
`default_nettype none
module gsc_dp #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int PW = 3 * COORD_BITS,
    localparam int AW = 2 * COORD_BITS + 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire gsc_pkg::t_cmd         i_cmd,
    input  wire logic [IW-1:0]         i_pt_raddr,
    input  wire logic [IW-1:0]         i_pt_waddr,
    input  wire logic [IW-1:0]         i_st_raddr,
    input  wire logic [IW-1:0]         i_st_waddr,
    input  wire logic [IW-1:0]         i_st_wdata,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    input  wire logic [COORD_BITS-1:0] i_z,
    output gsc_pkg::t_stat             o_stat,
    output logic [IW-1:0]              o_st_rdata,
    output logic [COORD_BITS-1:0]      o_x,
    output logic [COORD_BITS-1:0]      o_y,
    output logic [COORD_BITS-1:0]      o_z,
    output logic [1:0]                 o_status,
    output logic                       o_ovf,
    output logic                       o_last,
    output logic                       o_valid
);

    logic [PW-1:0] r_pv, r_t, r_q, r_a, r_b;
    logic [AW-1:0] r_dt;
    gsc_pkg::t_gsel r_gsel;

    logic [PW-1:0] pt_wdata, pt_rdata;
    logic [PW-1:0] g_a, g_b, g_c;
    logic          g_dist, g_done;
    logic [AW-1:0] g_res;

    always_comb begin
        unique case (i_cmd.wsel)
            gsc_pkg::WS_IN: pt_wdata = {i_z, i_y, i_x};
            gsc_pkg::WS_T:  pt_wdata = r_t;
            gsc_pkg::WS_Q:  pt_wdata = r_q;
            default:        pt_wdata = r_pv;
        endcase
    end

    gsc_ram #(.W(PW), .D(MAX_POINTS)) u_pts (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pt_we),
        .i_waddr (i_pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (i_cmd.pt_re),
        .i_raddr (i_pt_raddr),
        .o_rdata (pt_rdata)
    );

    gsc_ram #(.W(IW), .D(MAX_POINTS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.st_we),
        .i_waddr (i_st_waddr),
        .i_wdata (i_st_wdata),
        .i_re    (i_cmd.st_re),
        .i_raddr (i_st_raddr),
        .o_rdata (o_st_rdata)
    );

    always_comb begin
        unique case (r_gsel)
            gsc_pkg::GS_PTQ: begin g_a = r_pv; g_b = r_t; g_c = r_q; end
            gsc_pkg::GS_ABT: begin g_a = r_a;  g_b = r_b; g_c = r_t; end
            gsc_pkg::GS_DT:  begin g_a = r_t;  g_b = r_pv; g_c = r_q; end
            default:         begin g_a = r_q;  g_b = r_pv; g_c = r_t; end
        endcase
    end

    assign g_dist = (i_cmd.gsel == gsc_pkg::GS_DT) || (i_cmd.gsel == gsc_pkg::GS_DQ);

    gsc_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.g_start),
        .i_dist  (g_dist),
        .i_a     (g_a),
        .i_b     (g_b),
        .i_c     (g_c),
        .o_done  (g_done),
        .o_res   (g_res)
    );

    // lower y wins, then lower x
    logic signed [COORD_BITS-1:0] rd_x, rd_y, pv_x, pv_y;
    assign rd_x = $signed(pt_rdata[COORD_BITS-1:0]);
    assign rd_y = $signed(pt_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign pv_x = $signed(r_pv[COORD_BITS-1:0]);
    assign pv_y = $signed(r_pv[2*COORD_BITS-1:COORD_BITS]);

    assign o_stat.pt_lt    = (rd_y < pv_y) || ((rd_y == pv_y) && (rd_x < pv_x));
    assign o_stat.g_done   = g_done;
    assign o_stat.g_pos    = !g_res[AW-1] && (g_res != '0);
    assign o_stat.g_zero   = (g_res == '0);
    assign o_stat.t_nearer = $signed(r_dt) < $signed(g_res);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pv) r_pv <= pt_rdata;
        if (i_cmd.ld_t) begin
            r_t <= pt_rdata;
        end else if (i_cmd.t_from_q) begin
            r_t <= r_q;
        end
        if (i_cmd.ld_q) r_q <= pt_rdata;
        if (i_cmd.ld_a) begin
            r_a <= pt_rdata;
        end else if (i_cmd.a_from_b) begin
            r_a <= r_b;
        end
        if (i_cmd.ld_b) begin
            r_b <= pt_rdata;
        end else if (i_cmd.b_from_t) begin
            r_b <= r_t;
        end else if (i_cmd.b_from_a) begin
            r_b <= r_a;
        end
        if (i_cmd.ld_dt) r_dt <= g_res;
        if (i_cmd.g_start) r_gsel <= i_cmd.gsel;
        if (i_cmd.out_ld) begin
            o_x      <= i_cmd.out_zero ? '0 : pt_rdata[COORD_BITS-1:0];
            o_y      <= i_cmd.out_zero ? '0 : pt_rdata[2*COORD_BITS-1:COORD_BITS];
            o_z      <= i_cmd.out_zero ? '0 : pt_rdata[3*COORD_BITS-1:2*COORD_BITS];
            o_status <= i_cmd.out_status;
            o_ovf    <= i_cmd.out_ovf;
            o_last   <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_ld;
        end
    end

endmodule
`default_nettype wire

// ===== src/gsc_ctrl.sv =====
// Controller: load, pivot search, insertion sort, collinear pruning, scan and readout.
`default_nettype none
module gsc_ctrl #(
    parameter int MAX_POINTS = 64,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_last,
    output logic               o_busy,
    output gsc_pkg::t_cmd      o_cmd,
    output logic [IW-1:0]      o_pt_raddr,
    output logic [IW-1:0]      o_pt_waddr,
    output logic [IW-1:0]      o_st_raddr,
    output logic [IW-1:0]      o_st_waddr,
    output logic [IW-1:0]      o_st_wdata,
    input  wire gsc_pkg::t_stat i_stat,
    input  wire logic [IW-1:0] i_st_rdata
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHK    = 5'd1;
    localparam logic [4:0] S_PV_RD  = 5'd2;
    localparam logic [4:0] S_PV_CMP = 5'd3;
    localparam logic [4:0] S_SWAP0  = 5'd4;
    localparam logic [4:0] S_SWAP1  = 5'd5;
    localparam logic [4:0] S_SO_RDT = 5'd6;
    localparam logic [4:0] S_SO_LDT = 5'd7;
    localparam logic [4:0] S_SO_WDT = 5'd8;
    localparam logic [4:0] S_SO_CHK = 5'd9;
    localparam logic [4:0] S_SO_LDQ = 5'd10;
    localparam logic [4:0] S_SO_WTN = 5'd11;
    localparam logic [4:0] S_SO_WDQ = 5'd12;
    localparam logic [4:0] S_CO_TOP = 5'd13;
    localparam logic [4:0] S_CO_LDT = 5'd14;
    localparam logic [4:0] S_CO_NXT = 5'd15;
    localparam logic [4:0] S_CO_LDQ = 5'd16;
    localparam logic [4:0] S_CO_WT  = 5'd17;
    localparam logic [4:0] S_CO_CHM = 5'd18;
    localparam logic [4:0] S_SC_I0  = 5'd19;
    localparam logic [4:0] S_SC_I1  = 5'd20;
    localparam logic [4:0] S_SC_I2  = 5'd21;
    localparam logic [4:0] S_SC_TOP = 5'd22;
    localparam logic [4:0] S_SC_LDT = 5'd23;
    localparam logic [4:0] S_SC_TST = 5'd24;
    localparam logic [4:0] S_SC_WT  = 5'd25;
    localparam logic [4:0] S_SC_PA  = 5'd26;
    localparam logic [4:0] S_SC_PB  = 5'd27;
    localparam logic [4:0] S_EM_ST  = 5'd28;
    localparam logic [4:0] S_EM_PT  = 5'd29;
    localparam logic [4:0] S_EM_OUT = 5'd30;

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_m, n_m;
    logic [CW-1:0] r_sd, n_sd;
    logic [IW-1:0] r_best, n_best;

    logic sort_move, sort_place, push;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_j        = r_j;
        n_m        = r_m;
        n_sd       = r_sd;
        n_best     = r_best;
        o_cmd      = '0;
        o_pt_raddr = '0;
        o_pt_waddr = '0;
        o_st_raddr = '0;
        o_st_waddr = '0;
        o_st_wdata = '0;
        sort_move  = 1'b0;
        sort_place = 1'b0;
        push       = 1'b0;
        o_cmd.out_ovf = r_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (r_cnt < CW'(MAX_POINTS)) begin
                        o_cmd.pt_we = 1'b1;
                        o_cmd.wsel  = gsc_pkg::WS_IN;
                        o_pt_waddr  = r_cnt[IW-1:0];
                        n_cnt       = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_cnt < CW'(gsc_pkg::MIN_POINTS)) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.out_zero   = 1'b1;
                    o_cmd.out_status = gsc_pkg::STATUS_FEW;
                    o_cmd.out_last   = 1'b1;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_i     = '0;
                    n_state = S_PV_RD;
                end
            end
            S_PV_RD: begin
                o_cmd.pt_re = 1'b1;
                o_pt_raddr  = r_i[IW-1:0];
                n_state     = S_PV_CMP;
            end
            S_PV_CMP: begin
                if (r_i == '0) begin
                    o_cmd.ld_pv = 1'b1;
                    o_cmd.ld_t  = 1'b1;
                    n_best      = '0;
                end else if (i_stat.pt_lt) begin
                    o_cmd.ld_pv = 1'b1;
                    n_best      = r_i[IW-1:0];
                end
                n_i = r_i + CW'(1);
                if ((r_i + CW'(1)) < r_cnt) begin
                    n_state = S_PV_RD;
                end else begin
                    n_state = S_SWAP0;
                end
            end
            S_SWAP0: begin
                o_cmd.pt_we = 1'b1;
                o_cmd.wsel  = gsc_pkg::WS_T;
                o_pt_waddr  = r_best;
                n_state     = S_SWAP1;
            end
            S_SWAP1: begin
                o_cmd.pt_we = 1'b1;
                o_cmd.wsel  = gsc_pkg::WS_PV;
                o_pt_waddr  = '0;
                n_i         = CW'(2);
                n_state     = S_SO_RDT;
            end
            S_SO_RDT: begin
                o_cmd.pt_re = 1'b1;
                o_pt_raddr  = r_i[IW-1:0];
                n_state     = S_SO_LDT;
            end
            S_SO_LDT: begin
                o_cmd.ld_t    = 1'b1;
                o_cmd.g_start = 1'b1;
                o_cmd.gsel    = gsc_pkg::GS_DT;
                n_state       = S_SO_WDT;
            end
            S_SO_WDT: begin
                if (i_stat.g_done) begin
                    o_cmd.ld_dt = 1'b1;
                    n_j         = r_i;
                    n_state     = S_SO_CHK;
                end
            end
            S_SO_CHK: begin
                if (r_j > CW'(1)) begin
                    o_cmd.pt_re = 1'b1;
                    o_pt_raddr  = r_j[IW-1:0] - IW'(1);
                    n_state     = S_SO_LDQ;
                end else begin
                    sort_place = 1'b1;
                end
            end
            S_SO_LDQ: begin
                o_cmd.ld_q    = 1'b1;
                o_cmd.g_start = 1'b1;
                o_cmd.gsel    = gsc_pkg::GS_PTQ;
                n_state       = S_SO_WTN;
            end
            S_SO_WTN: begin
                if (i_stat.g_done) begin
                    if (i_stat.g_zero) begin
                        o_cmd.g_start = 1'b1;
                        o_cmd.gsel    = gsc_pkg::GS_DQ;
                        n_state       = S_SO_WDQ;
                    end else begin
                        if (i_stat.g_pos) sort_move = 1'b1;
                        else              sort_place = 1'b1;
                    end
                end
            end
            S_SO_WDQ: begin
                if (i_stat.g_done) begin
                    if (i_stat.t_nearer) sort_move = 1'b1;
                    else                 sort_place = 1'b1;
                end
            end
            S_CO_TOP: begin
                if (r_i < r_cnt) begin
                    o_cmd.pt_re = 1'b1;
                    o_pt_raddr  = r_i[IW-1:0];
                    n_state     = S_CO_LDT;
                end else begin
                    n_state = S_CO_CHM;
                end
            end
            S_CO_LDT: begin
                o_cmd.ld_t = 1'b1;
                n_state    = S_CO_NXT;
            end
            S_CO_NXT: begin
                if ((r_i + CW'(1)) < r_cnt) begin
                    o_cmd.pt_re = 1'b1;
                    o_pt_raddr  = r_i[IW-1:0] + IW'(1);
                    n_state     = S_CO_LDQ;
                end else begin
                    o_cmd.pt_we = 1'b1;
                    o_cmd.wsel  = gsc_pkg::WS_T;
                    o_pt_waddr  = r_m[IW-1:0];
                    n_m         = r_m + CW'(1);
                    n_i         = r_i + CW'(1);
                    n_state     = S_CO_TOP;
                end
            end
            S_CO_LDQ: begin
                o_cmd.ld_q    = 1'b1;
                o_cmd.g_start = 1'b1;
                o_cmd.gsel    = gsc_pkg::GS_PTQ;
                n_state       = S_CO_WT;
            end
            S_CO_WT: begin
                if (i_stat.g_done) begin
                    n_i = r_i + CW'(1);
                    if (i_stat.g_zero) begin
                        // collinear with the pivot: keep the farther one
                        o_cmd.t_from_q = 1'b1;
                        n_state        = S_CO_NXT;
                    end else begin
                        o_cmd.pt_we = 1'b1;
                        o_cmd.wsel  = gsc_pkg::WS_T;
                        o_pt_waddr  = r_m[IW-1:0];
                        n_m         = r_m + CW'(1);
                        n_state     = S_CO_TOP;
                    end
                end
            end
            S_CO_CHM: begin
                if (r_m < CW'(gsc_pkg::MIN_POINTS)) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.out_zero   = 1'b1;
                    o_cmd.out_status = gsc_pkg::STATUS_DEGEN;
                    o_cmd.out_last   = 1'b1;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SC_I0;
                end
            end
            S_SC_I0: begin
                o_cmd.st_we = 1'b1;
                o_st_waddr  = '0;
                o_st_wdata  = '0;
                o_cmd.pt_re = 1'b1;
                o_pt_raddr  = IW'(1);
                n_state     = S_SC_I1;
            end
            S_SC_I1: begin
                o_cmd.ld_a  = 1'b1;
                o_cmd.st_we = 1'b1;
                o_st_waddr  = IW'(1);
                o_st_wdata  = IW'(1);
                o_cmd.pt_re = 1'b1;
                o_pt_raddr  = IW'(2);
                n_state     = S_SC_I2;
            end
            S_SC_I2: begin
                o_cmd.ld_b  = 1'b1;
                o_cmd.st_we = 1'b1;
                o_st_waddr  = IW'(2);
                o_st_wdata  = IW'(2);
                n_sd        = CW'(3);
                n_i         = CW'(3);
                n_state     = S_SC_TOP;
            end
            S_SC_TOP: begin
                if (r_i < r_m) begin
                    o_cmd.pt_re = 1'b1;
                    o_pt_raddr  = r_i[IW-1:0];
                    n_state     = S_SC_LDT;
                end else begin
                    n_state = S_EM_ST;
                end
            end
            S_SC_LDT: begin
                o_cmd.ld_t = 1'b1;
                n_state    = S_SC_TST;
            end
            S_SC_TST: begin
                if (r_sd > CW'(2)) begin
                    o_cmd.g_start = 1'b1;
                    o_cmd.gsel    = gsc_pkg::GS_ABT;
                    n_state       = S_SC_WT;
                end else begin
                    push = 1'b1;
                end
            end
            S_SC_WT: begin
                if (i_stat.g_done) begin
                    if (i_stat.g_pos) begin
                        push = 1'b1;
                    end else begin
                        // pop; the old next-to-top becomes top, fetch the new one
                        o_cmd.b_from_a = 1'b1;
                        n_sd           = r_sd - CW'(1);
                        o_cmd.st_re    = 1'b1;
                        o_st_raddr     = r_sd[IW-1:0] - IW'(3);
                        n_state        = S_SC_PA;
                    end
                end
            end
            S_SC_PA: begin
                o_cmd.pt_re = 1'b1;
                o_pt_raddr  = i_st_rdata;
                n_state     = S_SC_PB;
            end
            S_SC_PB: begin
                o_cmd.ld_a = 1'b1;
                n_state    = S_SC_TST;
            end
            S_EM_ST: begin
                o_cmd.st_re = 1'b1;
                o_st_raddr  = r_sd[IW-1:0] - IW'(1);
                n_sd        = r_sd - CW'(1);
                n_state     = S_EM_PT;
            end
            S_EM_PT: begin
                o_cmd.pt_re = 1'b1;
                o_pt_raddr  = i_st_rdata;
                n_state     = S_EM_OUT;
            end
            S_EM_OUT: begin
                o_cmd.out_ld     = 1'b1;
                o_cmd.out_status = gsc_pkg::STATUS_HULL;
                o_cmd.out_last   = (r_sd == '0);
                if (r_sd == '0) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EM_ST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // insertion step: shift the compared word up, or drop t into its slot
        if (sort_move) begin
            o_cmd.pt_we = 1'b1;
            o_cmd.wsel  = gsc_pkg::WS_Q;
            o_pt_waddr  = r_j[IW-1:0];
            n_j         = r_j - CW'(1);
            n_state     = S_SO_CHK;
        end
        if (sort_place) begin
            o_cmd.pt_we = 1'b1;
            o_cmd.wsel  = gsc_pkg::WS_T;
            o_pt_waddr  = r_j[IW-1:0];
            if ((r_i + CW'(1)) < r_cnt) begin
                n_i     = r_i + CW'(1);
                n_state = S_SO_RDT;
            end else begin
                n_i     = CW'(1);
                n_m     = CW'(1);
                n_state = S_CO_TOP;
            end
        end
        if (push) begin
            o_cmd.st_we    = 1'b1;
            o_st_waddr     = r_sd[IW-1:0];
            o_st_wdata     = r_i[IW-1:0];
            o_cmd.a_from_b = 1'b1;
            o_cmd.b_from_t = 1'b1;
            n_sd           = r_sd + CW'(1);
            n_i            = r_i + CW'(1);
            n_state        = S_SC_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_sd    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_sd    <= n_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_m    <= n_m;
        r_best <= n_best;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_sd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd <= r_cnt)
        else $error("stack deeper than point count");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_ld && o_cmd.out_last) |=> (r_state == S_IDLE))
        else $error("run did not end after last word");

    a_geom_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.g_done |-> (r_state == S_SO_WDT || r_state == S_SO_WTN ||
                           r_state == S_SO_WDQ || r_state == S_CO_WT ||
                           r_state == S_SC_WT))
        else $error("geometry result with no one waiting");

endmodule
`default_nettype wire

// ===== src/graham_scan_convex_hull.sv =====
// Top level of the planar convex hull block.
//
// Input: a point word is taken on a clock edge with start high and busy low.
// Points are stored one per cycle; a word with i_last_point high ends the set
// and starts the hull run, during which busy stays high.
// Output: each result word is on the o_ ports for one cycle with o_hull_valid
// high; the receiver cannot stall. Hull vertices come from the top of the
// stack down, o_last_result marks the final word. Fewer than three points
// give one word with status 1, fewer than two distinct angles from the pivot one
// word with status 2. Points past capacity are dropped and flagged in o_overflowed.
// Run: a pivot search over the stored points, then an insertion sort by angle
// about the pivot with a turn test per compare, plus a distance test when the
// turn is zero (up to n^2/2 compares), then pruning of collinear points, the
// scan with a turn test per step or pop, and readout of each emitted vertex.
// The turn tests and distances share one multiply-accumulate unit, which sets
// the per-step cost. Reset clears counts and returns to idle.
`default_nettype none
module graham_scan_convex_hull #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] i_x_coord,
    input  wire logic [COORD_BITS-1:0] i_y_coord,
    input  wire logic [COORD_BITS-1:0] i_z_coord,
    input  wire logic                  i_last_point,
    output logic                       o_hull_valid,
    output logic [COORD_BITS-1:0]      o_hull_x,
    output logic [COORD_BITS-1:0]      o_hull_y,
    output logic [COORD_BITS-1:0]      o_hull_z,
    output logic [1:0]                 o_status,
    output logic                       o_overflowed,
    output logic                       o_last_result
);

    localparam int IW = $clog2(MAX_POINTS);

    gsc_pkg::t_cmd  cmd;
    gsc_pkg::t_stat stat;
    logic [IW-1:0]  pt_raddr, pt_waddr, st_raddr, st_waddr, st_wdata, st_rdata;

    gsc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last     (i_last_point),
        .o_busy     (busy),
        .o_cmd      (cmd),
        .o_pt_raddr (pt_raddr),
        .o_pt_waddr (pt_waddr),
        .o_st_raddr (st_raddr),
        .o_st_waddr (st_waddr),
        .o_st_wdata (st_wdata),
        .i_stat     (stat),
        .i_st_rdata (st_rdata)
    );

    gsc_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_pt_raddr (pt_raddr),
        .i_pt_waddr (pt_waddr),
        .i_st_raddr (st_raddr),
        .i_st_waddr (st_waddr),
        .i_st_wdata (st_wdata),
        .i_x        (i_x_coord),
        .i_y        (i_y_coord),
        .i_z        (i_z_coord),
        .o_stat     (stat),
        .o_st_rdata (st_rdata),
        .o_x        (o_hull_x),
        .o_y        (o_hull_y),
        .o_z        (o_hull_z),
        .o_status   (o_status),
        .o_ovf      (o_overflowed),
        .o_last     (o_last_result),
        .o_valid    (o_hull_valid)
    );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the planar convex hull block.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;

    typedef struct {
        logic [15:0] x, y, z;
        logic        last;
        logic        drain;   // hold until all hull words are back
    } t_point_word;

    typedef struct {
        logic [15:0] x, y, z;
        logic [1:0]  status;
        logic        ovf;
        logic        last;
    } t_hull_word;

    typedef struct { longint x, y, z; } t_pt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_x_coord = '0, i_y_coord = '0, i_z_coord = '0;
    logic        i_last_point = 1'b0;
    logic        o_hull_valid;
    logic [15:0] o_hull_x, o_hull_y, o_hull_z;
    logic [1:0]  o_status;
    logic        o_overflowed, o_last_result;

    graham_scan_convex_hull dut (.*);

    always #6 i_clk = ~i_clk;

    t_point_word point_q[$];
    t_hull_word  hull_q[$];
    t_pt         pts[CAP];
    int          n_pts = 0;
    bit          lost_pts = 0;
    int          errors = 0, n_accepted = 0, n_words = 0, n_sets = 0;

    function automatic longint turn_of(t_pt a, t_pt b, t_pt c);
        return (b.x - a.x) * (c.y - b.y) - (b.y - a.y) * (c.x - b.x);
    endfunction

    function automatic longint dsq(t_pt a, t_pt b);
        return (a.x-b.x)*(a.x-b.x) + (a.y-b.y)*(a.y-b.y) + (a.z-b.z)*(a.z-b.z);
    endfunction

    function automatic bit ahead_of(t_pt pv, t_pt a, t_pt b);
        longint o;
        o = turn_of(pv, a, b);
        if (o == 0) return dsq(a, pv) < dsq(b, pv);
        return o > 0;
    endfunction

    function automatic void push_word(t_pt p, logic [1:0] st, bit lst);
        t_hull_word w;
        w.x = p.x[15:0]; w.y = p.y[15:0]; w.z = p.z[15:0];
        w.status = st; w.ovf = lost_pts; w.last = lst;
        hull_q.insert(hull_q.size(), w);
    endfunction

    // fold one accepted point into the hull prediction
    function automatic void predict_hull(t_point_word w);
        t_pt    zp, tp;
        int     best, i, j, m, depth;
        int     stk[CAP];
        zp = '{0, 0, 0};
        if (n_pts < CAP) begin
            pts[n_pts] = '{longint'($signed(w.x)), longint'($signed(w.y)),
                           longint'($signed(w.z))};
            n_pts++;
        end else
            lost_pts = 1;
        if (!w.last) return;
        n_sets++;
        if (n_pts < gsc_pkg::MIN_POINTS) begin
            push_word(zp, gsc_pkg::STATUS_FEW, 1);
        end else begin
            best = 0;
            for (i = 1; i < n_pts; i++)
                if (pts[i].y < pts[best].y ||
                    (pts[i].y == pts[best].y && pts[i].x < pts[best].x))
                    best = i;
            tp = pts[0]; pts[0] = pts[best]; pts[best] = tp;
            for (i = 2; i < n_pts; i++) begin
                tp = pts[i];
                j = i;
                while (j > 1 && ahead_of(pts[0], tp, pts[j-1])) begin
                    pts[j] = pts[j-1];
                    j--;
                end
                pts[j] = tp;
            end
            // keep only the farthest of each collinear run
            m = 1;
            for (i = 1; i < n_pts; i++) begin
                while (i + 1 < n_pts && turn_of(pts[0], pts[i], pts[i+1]) == 0) i++;
                pts[m] = pts[i];
                m++;
            end
            if (m < gsc_pkg::MIN_POINTS) begin
                push_word(zp, gsc_pkg::STATUS_DEGEN, 1);
            end else begin
                stk[0] = 0; stk[1] = 1; stk[2] = 2; depth = 3;
                for (i = 3; i < m; i++) begin
                    while (depth > 2 &&
                           turn_of(pts[stk[depth-2]], pts[stk[depth-1]], pts[i]) <= 0)
                        depth--;
                    stk[depth] = i;
                    depth++;
                end
                while (depth > 0) begin
                    depth--;
                    push_word(pts[stk[depth]], gsc_pkg::STATUS_HULL, depth == 0);
                end
            end
        end
        n_pts = 0;
        lost_pts = 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_hull(point_q.pop_front());
                n_accepted++;
            end
            if (point_q.size() > 0 && !(point_q[0].drain && hull_q.size() != 0) &&
                ((n_accepted > 30 && n_accepted < 70) || $urandom_range(99) >= 17)) begin
                i_x_coord    <= point_q[0].x;
                i_y_coord    <= point_q[0].y;
                i_z_coord    <= point_q[0].z;
                i_last_point <= point_q[0].last;
                start        <= 1'b1;
            end else begin
                start        <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_hull_valid) begin
            if (hull_q.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h z=%h st=%0d", $realtime,
                         o_hull_x, o_hull_y, o_hull_z, o_status);
                errors++;
            end else begin
                t_hull_word e;
                e = hull_q.pop_front();
                n_words++;
                if (e.x !== o_hull_x || e.y !== o_hull_y || e.z !== o_hull_z ||
                    e.status !== o_status || e.ovf !== o_overflowed ||
                    e.last !== o_last_result) begin
                    $display("%0t: mismatch exp x=%h y=%h z=%h st=%0d ovf=%b last=%b",
                             $realtime, e.x, e.y, e.z, e.status, e.ovf, e.last);
                    $display("%0t:          got x=%h y=%h z=%h st=%0d ovf=%b last=%b",
                             $realtime, o_hull_x, o_hull_y, o_hull_z, o_status,
                             o_overflowed, o_last_result);
                    errors++;
                end
            end
        end
    end

    function automatic void add_pt(int x, int y, int z, bit lst, bit drn = 0);
        t_point_word w;
        w.x = x[15:0]; w.y = y[15:0]; w.z = z[15:0]; w.last = lst; w.drain = drn;
        point_q.insert(point_q.size(), w);
    endfunction

    // one random set; style picks full range, tight cluster or a lattice
    function automatic void add_set(int cnt, int style);
        int k, x, y;
        for (k = 0; k < cnt; k++) begin
            case (style)
                0: begin x = $urandom; y = $urandom; end
                1: begin x = $urandom_range(6) - 3; y = $urandom_range(6) - 3; end
                default: begin
                    x = 2 * ($urandom_range(4)) - 32768;
                    y = 3 * ($urandom_range(4)) + 32760;
                end
            endcase
            add_pt(x, y, $urandom, k == cnt - 1);
        end
    endfunction

    initial begin
        int k;
        // too few points
        add_pt(5, 5, 5, 1);
        add_pt(-32768, 32767, -1, 0); add_pt(32767, -32768, 0, 1);
        // all collinear, degenerate
        add_pt(0, 0, 0, 0); add_pt(10, 10, 3, 0); add_pt(20, 20, -3, 0);
        add_pt(-5, -5, 7, 1);
        // range corners with an interior, a duplicate and a tied low point
        add_pt(32767, 32767, 32767, 0); add_pt(-32768, -32768, -32768, 0);
        add_pt(32767, -32768, 1, 0); add_pt(-32768, 32767, 2, 0);
        add_pt(0, 0, 9, 0); add_pt(32767, 32767, -9, 0);
        add_pt(0, -32768, 4, 0); add_pt(0, 32767, 4, 1, 1);
        // square with collinear edge points and equal-distance ties
        add_pt(0, 0, 0, 0); add_pt(4, 0, 0, 0); add_pt(2, 0, 1, 0);
        add_pt(2, 0, -1, 0); add_pt(4, 4, 0, 0); add_pt(0, 4, 0, 0);
        add_pt(2, 2, 0, 1);
        // store overflow, dropped last point
        for (k = 0; k < CAP + 2; k++)
            add_pt($urandom, $urandom, $urandom, k == CAP + 1, k == 0);
        while (point_q.size() < 105) add_set($urandom_range(10, 3), $urandom_range(2));
        add_set(1, 0);
        add_set(2, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (point_q.size() == 0 && hull_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (hull_q.size() != 0) begin
            $display("%0t: %0d hull words never came", $realtime, hull_q.size());
            errors++;
        end
        $display("Covered %0d points in %0d sets, %0d hull words checked,", n_accepted,
                 n_sets, n_words);
        $display("including short, collinear, overflowing and extreme-range sets.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== graham_scan_convex_hull.f =====
src/gsc_pkg.sv
src/gsc_ram.sv
src/gsc_geom.sv
src/gsc_dp.sv
src/gsc_ctrl.sv
src/graham_scan_convex_hull.sv
tb/sv/testbench.sv
